// ===== rtl/core/rmu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmu_pkg
// Shared types and constants for the regret matching update block.
// ----------------------------------------------------------------------------
package rmu_pkg;

  localparam int SLOT_W   = 12;
  localparam int ACT_W    = 3;
  localparam int VAL_W    = 32;
  localparam int PROB_W   = 17;
  localparam int MAX_EMIT = 8;
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

  // Divider request: pos * 2^16 / sum, or 2^16 / count when sum is 0.
  typedef struct packed {
    logic [47:0] num;
    logic [34:0] den;
  } rmu_div_req_t;

endpackage

// ===== rtl/core/regret_matching_update_top.sv =====
// ----------------------------------------------------------------------------
// regret_matching_update_top
// Cumulative regret store with saturating update and strategy output.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes all 2**(RW+AW) entries (32768 by default)
// of the store; no request is taken during it.
// Non-last request: accept, read, then modify and write back in one memory.
// Last request: those steps, then a read and an accumulate per entry to sum,
// then per entry a read, a divider start, serial division and one output beat.
// The divider and the single memory port set the rate; output stalls add to it.
module regret_matching_update_top #(
  parameter int MAX_ACTIONS = 8,
  parameter int NUM_SLOTS   = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rmu_pkg::SLOT_W-1:0]       in_slot,
  input  logic [rmu_pkg::ACT_W-1:0]        in_action,
  input  logic signed [rmu_pkg::VAL_W-1:0] in_child_value,
  input  logic signed [rmu_pkg::VAL_W-1:0] in_node_value,
  input  logic                             in_update_enable,
  input  logic                             in_last_action,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rmu_pkg::SLOT_W-1:0]       out_slot,
  output logic [rmu_pkg::ACT_W-1:0]        out_action,
  output logic [rmu_pkg::PROB_W-1:0]       out_probability,
  output logic                             out_last
);
  import rmu_pkg::*;

  localparam int RW    = $clog2(NUM_SLOTS);
  localparam int AW    = $clog2(MAX_ACTIONS);
  localparam int MW    = RW + AW;
  localparam int DEPTH = 2 ** MW;
  localparam int NMAX  = (MAX_ACTIONS < MAX_EMIT) ? MAX_ACTIONS : MAX_EMIT;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_WR, S_SRD, S_SACC, S_PRD, S_PDIV, S_PWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;
  logic [MW-1:0]    clr_r;
  logic [RW-1:0]    row_r;
  logic [ACT_W-1:0] act_r;
  logic [3:0]       n_r;
  logic [ACT_W:0]   k_r;
  logic signed [VAL_W-1:0] diff_a_r, diff_b_r;
  logic             upd_r, last_r;
  logic [34:0]      sum_r;
  logic             div_start;
  rmu_div_req_t     div_req;
  logic             div_done;
  logic [16:0]      quot;

  // memory address selection
  logic [MW-1:0]    addr;
  logic [AW-1:0]    k_idx, a_idx;
  logic             act_ok;
  logic signed [VAL_W+1:0] upd_sum;
  logic [VAL_W-1:0] upd_val;
  logic [RW-1:0]    in_row;

  assign in_row = RW'(in_slot % NUM_SLOTS);
  assign k_idx  = AW'(k_r);
  assign a_idx  = AW'(act_r);
  assign act_ok = (int'(act_r) < MAX_ACTIONS);
  assign addr   = (state_r == S_RD || state_r == S_WR) ? {row_r, a_idx} : {row_r, k_idx};

  // saturating update
  always_comb begin
    upd_sum = (VAL_W+2)'($signed(rdata_r)) + (VAL_W+2)'(diff_a_r) - (VAL_W+2)'(diff_b_r);
    if (upd_sum > (VAL_W+2)'(32'sh7fffffff))
      upd_val = 32'h7fffffff;
    else if (upd_sum < -(VAL_W+2)'(33'sh080000000))
      upd_val = 32'h80000000;
    else
      upd_val = upd_sum[VAL_W-1:0];
  end

  // single-port store
  always_ff @(posedge clk) begin
    if (state_r == S_CLR)
      mem[clr_r] <= '0;
    else if (state_r == S_WR && upd_r && act_ok)
      mem[addr] <= upd_val;
    rdata_r <= mem[addr];
  end

  assign div_start   = (state_r == S_PDIV);
  assign div_req.num = (sum_r == '0) ? 48'(ONE_Q16) :
                       (rdata_r[VAL_W-1] ? 48'd0 : {1'b0, rdata_r[VAL_W-2:0], 16'd0});
  assign div_req.den = (sum_r == '0) ? 35'(n_r) : sum_r;

  rmu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(div_req),
    .done(div_done), .quot(quot)
  );

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + MW'(1);
          if (clr_r == MW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          row_r    <= in_row;
          act_r    <= in_action;
          diff_a_r <= in_child_value;
          diff_b_r <= in_node_value;
          upd_r    <= in_update_enable;
          last_r   <= in_last_action;
          state_r  <= S_RD;
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (last_r) begin
            n_r     <= act_ok ? 4'({1'b0, act_r} + 4'd1) : 4'(NMAX);
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_SRD;
          end else state_r <= S_IDLE;
        end
        S_SRD: state_r <= S_SACC;
        S_SACC: begin
          if (!rdata_r[VAL_W-1]) sum_r <= sum_r + 35'(rdata_r);
          if (4'(k_r) + 4'd1 == n_r) begin
            k_r <= '0; state_r <= S_PRD;
          end else begin
            k_r <= k_r + (ACT_W+1)'(1); state_r <= S_SRD;
          end
        end
        S_PRD:  state_r <= S_PDIV;
        S_PDIV: state_r <= S_PWAIT;
        S_PWAIT: if (div_done) begin
          out_valid       <= 1'b1;
          out_slot        <= SLOT_W'(row_r);
          out_action      <= ACT_W'(k_r);
          out_probability <= quot;
          out_last        <= (4'(k_r) + 4'd1 == n_r);
          state_r         <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) state_r <= S_IDLE;
          else begin
            k_r <= k_r + (ACT_W+1)'(1); state_r <= S_PRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rmu_div.sv =====
// ----------------------------------------------------------------------------
// rmu_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module rmu_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rmu_pkg::rmu_div_req_t req,
  output logic                 done,
  output logic [16:0]          quot
);
  import rmu_pkg::*;

  // Quotient is known to fit in 17 bits (pos <= sum), so only the low 17
  // numerator bit positions are walked; the remainder starts with the top.
  logic [35:0] rem_r, rem_nxt;
  logic [34:0] den_r;
  logic [16:0] q_r, q_nxt;
  logic [16:0] nlo_r, nlo_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [35:0] sh;

  always_comb begin
    sh      = {rem_r[34:0], nlo_r[16]};
    nlo_nxt = {nlo_r[15:0], 1'b0};
    if (sh >= {1'b0, den_r}) begin
      rem_nxt = sh - {1'b0, den_r};
      q_nxt   = {q_r[15:0], 1'b1};
    end else begin
      rem_nxt = sh;
      q_nxt   = {q_r[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd17;
        rem_r  <= {5'd0, req.num[47:17]};
        nlo_r  <= req.num[16:0];
        den_r  <= req.den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        nlo_r <= nlo_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;

endmodule

// ===== rtl/core/rmu_checker.sv =====
// ----------------------------------------------------------------------------
// rmu_checker
// Port-level checks for the regret matching update block.
// ----------------------------------------------------------------------------
module rmu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_probability,
  input logic        out_last
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability))
    else $error("result dropped under stall");
  // never above 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= 17'd65536)
    else $error("probability out of range");
  // no request taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted during output");
  // after the last result completes, block returns to accept
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("block not idle after row");
endmodule

bind regret_matching_update_top rmu_checker u_rmu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_probability(out_probability), .out_last(out_last)
);
